@@ sv/mmpd_pkg.sv @@
package mmpd_pkg;

   localparam int NUM_BINS  = 60;
   localparam int BIN_AW    = $clog2(NUM_BINS);
   localparam int SCORE_W   = 8;
   localparam int SYM_W     = 2;
   localparam int POS_W     = 6;
   localparam int AMT_W     = 3;
   localparam int BACK_DIST = 21;

   localparam logic [SCORE_W-1:0] SCORE_MAX  = 8'd255;
   localparam logic [SCORE_W-1:0] THR_RESET  = 8'd12;
   localparam logic [AMT_W-1:0]   SYNC_BONUS = 3'd6;
   localparam logic [AMT_W-1:0]   PENALTY    = 3'd2;
   localparam logic [AMT_W-1:0]   BIT_BONUS  = 3'd1;
   localparam logic [AMT_W-1:0]   NO_CHANGE  = 3'd0;

   typedef logic [BIN_AW-1:0]  bin_addr_type;
   typedef logic [SCORE_W-1:0] score_type;

   typedef enum logic [SYM_W-1:0] {
      SYM_SYNC  = 2'd0,
      SYM_UNDEF = 2'd1,
      SYM_ZERO  = 2'd2,
      SYM_ONE   = 2'd3
   } symbol_type;

   typedef enum logic [1:0] {
      TGT_CUR,
      TGT_PREV,
      TGT_NEXT,
      TGT_BACK
   } tgt_type;

   typedef struct packed {
      tgt_type          tgt;
      logic             sub;
      logic [AMT_W-1:0] amt;
   } bin_op_type;

   typedef struct packed {
      logic         en;
      bin_addr_type addr;
      score_type    data;
   } bin_wr_type;

   typedef struct packed {
      logic         clear;
      logic         step;
      bin_addr_type idx;
   } scan_ctl_type;

   typedef struct packed {
      score_type    peak;
      score_type    runner;
      bin_addr_type idx;
   } scan_res_type;

   // Four update slots per symbol; bins touched in one symbol are distinct,
   // so slot order does not matter. Unused slots add nothing to the current bin.
   function automatic bin_op_type slot_op(input symbol_type sym, input logic [1:0] slot);
      bin_op_type op;
      op = '{tgt: TGT_CUR, sub: 1'b0, amt: NO_CHANGE};
      case (sym)
         SYM_SYNC: begin
            case (slot)
               2'd0:    op = '{tgt: TGT_CUR,  sub: 1'b0, amt: SYNC_BONUS};
               2'd1:    op = '{tgt: TGT_PREV, sub: 1'b1, amt: PENALTY};
               2'd2:    op = '{tgt: TGT_BACK, sub: 1'b1, amt: PENALTY};
               default: op = '{tgt: TGT_NEXT, sub: 1'b1, amt: PENALTY};
            endcase
         end
         SYM_UNDEF: begin
            case (slot)
               2'd0:    op = '{tgt: TGT_CUR,  sub: 1'b1, amt: PENALTY};
               2'd1:    op = '{tgt: TGT_PREV, sub: 1'b1, amt: PENALTY};
               2'd2:    op = '{tgt: TGT_BACK, sub: 1'b1, amt: PENALTY};
               default: op = '{tgt: TGT_CUR,  sub: 1'b0, amt: NO_CHANGE};
            endcase
         end
         SYM_ZERO: begin
            case (slot)
               2'd0:    op = '{tgt: TGT_PREV, sub: 1'b0, amt: BIT_BONUS};
               2'd1:    op = '{tgt: TGT_BACK, sub: 1'b1, amt: PENALTY};
               2'd2:    op = '{tgt: TGT_CUR,  sub: 1'b1, amt: PENALTY};
               default: op = '{tgt: TGT_CUR,  sub: 1'b0, amt: NO_CHANGE};
            endcase
         end
         default: begin
            case (slot)
               2'd0:    op = '{tgt: TGT_BACK, sub: 1'b0, amt: BIT_BONUS};
               2'd1:    op = '{tgt: TGT_PREV, sub: 1'b1, amt: PENALTY};
               2'd2:    op = '{tgt: TGT_CUR,  sub: 1'b1, amt: PENALTY};
               default: op = '{tgt: TGT_CUR,  sub: 1'b0, amt: NO_CHANGE};
            endcase
         end
      endcase
      return op;
   endfunction

endpackage

@@ sv/minute_mark_phase_detector.sv @@
// Minute mark phase detector.
// Input channel req_*: one decoded second symbol per item (sync mark,
// undefined, zero, one), valid/ready handshake. Result channel rsp_*: one
// item per symbol with the peak bin index, peak and runner-up scores, lock
// state and a lock-toggle flag. csr_wr_en/csr_wr_data write the lock
// threshold; write it only while the block is idle.
// Each item runs on a small sequencer around one score memory with a single
// read and write port: four read/modify/write passes through the saturating
// adder, then a scan of one bin per cycle over all NUM_BINS bins, a drain
// state that empties the read pipeline and a finish state that forms the
// result. req_ready is low from the accepted item until its result is loaded
// into the output register, so a new item waits until the last is through.
// A finished result sits in the output register; the next item is accepted
// while it waits. If rsp_ready stays low, the following result waits at the
// end of its scan until the register frees up.
// Reset clears all bins (per-bin valid flags, no sweep), the position, the
// lock flag, and sets the threshold to 12.
module minute_mark_phase_detector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mmpd_pkg::SYM_W-1:0]   req_symbol,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mmpd_pkg::POS_W-1:0]   rsp_mark_position,
   output logic [mmpd_pkg::SCORE_W-1:0] rsp_peak_score,
   output logic [mmpd_pkg::SCORE_W-1:0] rsp_runner_up_score,
   output logic                         rsp_is_locked,
   output logic                         rsp_lock_changed,
   input  logic                         csr_wr_en,
   input  logic [mmpd_pkg::SCORE_W-1:0] csr_wr_data
);
   import mmpd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type    state_ff,    state_in;
   symbol_type   sym_ff,      sym_in;
   logic [1:0]   slot_ff,     slot_in;
   bin_addr_type pos_ff,      pos_in;
   bin_addr_type scan_cnt_ff, scan_cnt_in;
   logic         cmp_valid_ff, cmp_valid_in;
   bin_addr_type cmp_idx_ff,  cmp_idx_in;
   logic         locked_ff,   locked_in;
   score_type    thr_ff,      thr_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] pos_out_ff, pos_out_in;
   score_type    peak_out_ff,   peak_out_in;
   score_type    runner_out_ff, runner_out_in;
   logic         lock_out_ff,   lock_out_in;
   logic         chg_out_ff,    chg_out_in;

   bin_op_type   cur_op;
   bin_addr_type prev_pos, next_pos, back_pos, tgt_addr, rd_addr;
   score_type    rd_data, alu_out, margin;
   bin_wr_type   wr;
   scan_ctl_type scan_ctl;
   scan_res_type scan_res;
   logic         locked_new, out_free;

   assign cur_op   = slot_op(sym_ff, slot_ff);
   assign next_pos = (pos_ff == BIN_AW'(NUM_BINS - 1)) ? '0 : pos_ff + 1'b1;
   assign prev_pos = (pos_ff == '0) ? BIN_AW'(NUM_BINS - 1) : pos_ff - 1'b1;
   assign back_pos = (pos_ff >= BIN_AW'(BACK_DIST)) ? pos_ff - BIN_AW'(BACK_DIST)
                                                     : pos_ff + BIN_AW'(NUM_BINS - BACK_DIST);

   always_comb begin
      case (cur_op.tgt)
         TGT_CUR:  tgt_addr = pos_ff;
         TGT_PREV: tgt_addr = prev_pos;
         TGT_NEXT: tgt_addr = next_pos;
         TGT_BACK: tgt_addr = back_pos;
         default:  tgt_addr = pos_ff;
      endcase
   end

   assign rd_addr  = (state_ff == ST_UPD_RD) ? tgt_addr : scan_cnt_ff;
   assign wr       = '{en: (state_ff == ST_UPD_WR), addr: tgt_addr, data: alu_out};
   assign scan_ctl = '{clear: (state_ff == ST_UPD_RD) && (slot_ff == 2'd0),
                       step: cmp_valid_ff, idx: cmp_idx_ff};

   mmpd_bin_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   mmpd_bin_alu u_alu (
      .value  (rd_data),
      .op     (cur_op),
      .result (alu_out)
   );

   mmpd_peak_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .data  (rd_data),
      .res   (scan_res)
   );

   assign margin     = scan_res.peak - scan_res.runner;
   assign locked_new = margin > thr_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      sym_in        = sym_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_valid_in  = (state_ff == ST_SCAN);
      cmp_idx_in    = scan_cnt_ff;
      locked_in     = locked_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pos_out_in    = pos_out_ff;
      peak_out_in   = peak_out_ff;
      runner_out_in = runner_out_ff;
      lock_out_in   = lock_out_ff;
      chg_out_in    = chg_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in   = symbol_type'(req_symbol);
               slot_in  = '0;
               state_in = ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            slot_in = slot_ff + 1'b1;
            if (slot_ff == 2'd3) begin
               pos_in      = next_pos;
               scan_cnt_in = '0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_UPD_RD;
            end
         end
         ST_SCAN: begin
            // counter parks on the last bin so the read address stays in range
            if (scan_cnt_ff == BIN_AW'(NUM_BINS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               locked_in     = locked_new;
               rsp_valid_in  = 1'b1;
               pos_out_in    = POS_W'(scan_res.idx);
               peak_out_in   = scan_res.peak;
               runner_out_in = scan_res.runner;
               lock_out_in   = locked_new;
               chg_out_in    = locked_new != locked_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         pos_ff        <= '0;
         scan_cnt_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         locked_ff     <= 1'b0;
         thr_ff        <= THR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         pos_ff        <= pos_in;
         scan_cnt_ff   <= scan_cnt_in;
         cmp_valid_ff  <= cmp_valid_in;
         locked_ff     <= locked_in;
         thr_ff        <= thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      cmp_idx_ff    <= cmp_idx_in;
      pos_out_ff    <= pos_out_in;
      peak_out_ff   <= peak_out_in;
      runner_out_ff <= runner_out_in;
      lock_out_ff   <= lock_out_in;
      chg_out_ff    <= chg_out_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mark_position   = pos_out_ff;
   assign rsp_peak_score      = peak_out_ff;
   assign rsp_runner_up_score = runner_out_ff;
   assign rsp_is_locked       = lock_out_ff;
   assign rsp_lock_changed    = chg_out_ff;

   a_runner_le_peak: assert property (@(posedge clock) disable iff (reset)
      scan_res.runner <= scan_res.peak)
      else $error("runner-up score above peak");

   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= BIN_AW'(NUM_BINS - 1))
      else $error("position outside ring");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !wr.en)
      else $error("item accepted while busy or write without read");

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && rsp_valid_in |-> state_ff == ST_FINISH)
      else $error("result raised outside finish");

endmodule

@@ sv/mmpd_bin_store.sv @@
module mmpd_bin_store (
   input  logic                   clock,
   input  logic                   reset,
   input  mmpd_pkg::bin_addr_type rd_addr,
   input  mmpd_pkg::bin_wr_type   wr,
   output mmpd_pkg::score_type    rd_data
);
   import mmpd_pkg::*;

   score_type    mem_ff [NUM_BINS];
   logic         valid_ff [NUM_BINS];
   score_type    rd_data_ff;
   logic         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // a bin never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ sv/mmpd_bin_alu.sv @@
module mmpd_bin_alu (
   input  mmpd_pkg::score_type  value,
   input  mmpd_pkg::bin_op_type op,
   output mmpd_pkg::score_type  result
);
   import mmpd_pkg::*;

   logic [SCORE_W:0] sum;
   score_type        amt_ext;

   assign amt_ext = SCORE_W'(op.amt);
   assign sum     = {1'b0, value} + {1'b0, amt_ext};

   always_comb begin
      if (op.sub) begin
         result = (value <= amt_ext) ? '0 : value - amt_ext;
      end else begin
         result = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
      end
   end

endmodule

@@ sv/mmpd_peak_scan.sv @@
module mmpd_peak_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  mmpd_pkg::scan_ctl_type ctl,
   input  mmpd_pkg::score_type    data,
   output mmpd_pkg::scan_res_type res
);
   import mmpd_pkg::*;

   score_type    peak_ff,   peak_in;
   score_type    runner_ff, runner_in;
   bin_addr_type idx_ff,    idx_in;

   always_comb begin
      peak_in   = peak_ff;
      runner_in = runner_ff;
      idx_in    = idx_ff;
      if (ctl.clear) begin
         peak_in   = '0;
         runner_in = '0;
         idx_in    = '0;
      end else if (ctl.step) begin
         // equal score takes over the peak, so the last tied bin wins
         if (data >= peak_ff) begin
            runner_in = peak_ff;
            peak_in   = data;
            idx_in    = ctl.idx;
         end else if (data > runner_ff) begin
            runner_in = data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= '0;
         runner_ff <= '0;
         idx_ff    <= '0;
      end else begin
         peak_ff   <= peak_in;
         runner_ff <= runner_in;
         idx_ff    <= idx_in;
      end
   end

   assign res = '{peak: peak_ff, runner: runner_ff, idx: idx_ff};

endmodule
